// File: sv/drm_pkg.sv
// ---------------------------------------------------------------------------
// drm_pkg: shared types and constants for the drum note mapper
// Field widths, register indexes and the lookup result struct.
// ---------------------------------------------------------------------------
package drm_pkg;

  localparam int CH_W       = 4;
  localparam int KEY_W      = 7;
  localparam int VEL_W      = 7;
  localparam int TIME_W     = 32;
  localparam int REG_W      = 56;   // widest configuration register
  localparam int CNT_W      = 4;    // instrument count register
  localparam int SCNT_W     = 3;    // one slot count field
  localparam int SCNTS_W    = 24;   // slot count register
  localparam int PTR_W      = 3;    // round-robin pointer
  localparam int INST_W     = 3;    // instrument number, up to eight
  localparam int CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INST_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INST_KEYS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNTS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT0_KEYS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT1_KEYS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT2_KEYS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT3_KEYS = 3'd6;

  typedef struct packed {
    logic              hit;        // matched note-on with a nonempty slot list
    logic [INST_W-1:0] inst;       // first matching instrument
    logic [PTR_W-1:0]  ptr_next;   // pointer value after this hit
    logic [KEY_W-1:0]  okey;       // mapped output key
  } drm_match_t;

endpackage

// File: sv/drm_if.sv
// ---------------------------------------------------------------------------
// drm_if: event and note channel interfaces
// Valid/ready channels carrying one input event or one output note per beat.
// ---------------------------------------------------------------------------
interface drm_event_if
  import drm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              is_note;
  logic              is_note_off;
  logic [CH_W-1:0]   channel;
  logic [KEY_W-1:0]  key;
  logic [VEL_W-1:0]  velocity;
  logic [TIME_W-1:0] event_time;

  modport source (output valid, is_note, is_note_off, channel, key, velocity, event_time,
                  input ready);
  modport sink (input valid, is_note, is_note_off, channel, key, velocity, event_time,
                output ready);
endinterface

interface drm_note_if
  import drm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   out_channel;
  logic [KEY_W-1:0]  out_key;
  logic [VEL_W-1:0]  out_velocity;
  logic [TIME_W-1:0] out_time;
  logic              last;

  modport source (output valid, out_channel, out_key, out_velocity, out_time, last,
                  input ready);
  modport sink (input valid, out_channel, out_key, out_velocity, out_time, last,
                output ready);
endinterface

// File: sv/drm_match.sv
// ---------------------------------------------------------------------------
// drm_match: instrument lookup and round-robin slot pick
// First matching instrument in list order, clamped counts, output key select.
// ---------------------------------------------------------------------------
module drm_match
  import drm_pkg::*;
#(
  parameter int NUM_INSTRUMENTS = 8,
  parameter int NUM_SLOTS       = 4
) (
  input  logic                                is_note,
  input  logic                                is_note_off,
  input  logic [KEY_W-1:0]                    key,
  input  logic [CNT_W-1:0]                    instrument_count,
  input  logic [REG_W-1:0]                    instrument_keys,
  input  logic [SCNTS_W-1:0]                  slot_counts,
  input  logic [NUM_SLOTS-1:0][REG_W-1:0]     slot_keys,
  input  logic [NUM_INSTRUMENTS-1:0][PTR_W-1:0] next_slot,
  output drm_match_t                          result
);

  logic [CNT_W-1:0]             n_eff;
  logic                         found;
  logic [INST_W-1:0]            sel;
  logic [SCNT_W-1:0]            cnt_raw;
  logic [SCNT_W-1:0]            cnt;
  logic [PTR_W-1:0]             ptr;
  logic [PTR_W-1:0]             slot;
  logic [NUM_SLOTS-1:0][KEY_W-1:0] cand_keys;
  logic [KEY_W-1:0]             okey;

  always_comb begin
    n_eff = (instrument_count > CNT_W'(NUM_INSTRUMENTS)) ? CNT_W'(NUM_INSTRUMENTS)
                                                         : instrument_count;
    found     = 1'b0;
    sel       = '0;
    cnt_raw   = '0;
    ptr       = '0;
    cand_keys = '0;
    // walk downward so the lowest matching instrument wins
    for (int i = NUM_INSTRUMENTS - 1; i >= 0; i--) begin
      if (CNT_W'(i) < n_eff && instrument_keys[KEY_W*i +: KEY_W] == key) begin
        found   = 1'b1;
        sel     = INST_W'(i);
        cnt_raw = slot_counts[SCNT_W*i +: SCNT_W];
        ptr     = next_slot[i];
        for (int s = 0; s < NUM_SLOTS; s++) begin
          cand_keys[s] = slot_keys[s][KEY_W*i +: KEY_W];
        end
      end
    end

    cnt  = (cnt_raw > SCNT_W'(NUM_SLOTS)) ? SCNT_W'(NUM_SLOTS) : cnt_raw;
    slot = (ptr >= PTR_W'(cnt)) ? '0 : ptr;

    okey = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (slot == PTR_W'(s)) begin
        okey = cand_keys[s];
      end
    end

    result.hit      = is_note && !is_note_off && found && (cnt != '0);
    result.inst     = sel;
    result.ptr_next = slot + PTR_W'(1);
    result.okey     = okey;
  end

endmodule

// File: sv/drum_note_round_robin_mapper_top.sv
// ---------------------------------------------------------------------------
// drum_note_round_robin_mapper_top: drum note round-robin mapper
// Maps note-ons on drum instrument keys to a rotating set of output keys.
// ---------------------------------------------------------------------------
// Each accepted event beat is registered, then looked up combinationally: the
// first configured instrument (in list order) whose input key matches a
// note-on picks its next output slot round robin, and the block emits two
// note beats, a note-on with the input velocity and a note-off with velocity
// 0 marked by last. Events that do not map are absorbed one per cycle with no
// output while no mapped event waits in the input register. A mapped event
// occupies the single output register for two beats. The input register can
// take one new event while the output register still holds a pending
// note-off; a mapped event there waits until the note-off beat is taken.
// Configuration registers are written through wr_en/wr_index/wr_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Writes to an index past the last slot key register are
// ignored.
// ---------------------------------------------------------------------------
module drum_note_round_robin_mapper_top
  import drm_pkg::*;
#(
  parameter int NUM_INSTRUMENTS = 8,
  parameter int NUM_SLOTS       = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  drm_event_if.sink            events,
  drm_note_if.source           notes
);

  // configuration
  logic [CNT_W-1:0]                   instrument_count;
  logic [REG_W-1:0]                   instrument_keys;
  logic [SCNTS_W-1:0]                 slot_counts;
  logic [NUM_SLOTS-1:0][REG_W-1:0]    slot_keys;

  // round-robin pointers, one per instrument
  logic [NUM_INSTRUMENTS-1:0][PTR_W-1:0] next_slot;

  // input register
  logic              ev_valid;
  logic              ev_is_note;
  logic              ev_is_note_off;
  logic [CH_W-1:0]   ev_channel;
  logic [KEY_W-1:0]  ev_key;
  logic [VEL_W-1:0]  ev_velocity;
  logic [TIME_W-1:0] ev_time;

  // output register; phase 0 = note-on beat, 1 = note-off beat
  logic              out_valid;
  logic              phase;
  logic [CH_W-1:0]   out_channel;
  logic [KEY_W-1:0]  out_key;
  logic [VEL_W-1:0]  out_velocity;
  logic [TIME_W-1:0] out_time;

  drm_match_t match;
  logic       out_free;
  logic       ev_adv;
  logic       in_ready;

  drm_match #(
    .NUM_INSTRUMENTS (NUM_INSTRUMENTS),
    .NUM_SLOTS       (NUM_SLOTS)
  ) u_match (
    .is_note          (ev_is_note),
    .is_note_off      (ev_is_note_off),
    .key              (ev_key),
    .instrument_count (instrument_count),
    .instrument_keys  (instrument_keys),
    .slot_counts      (slot_counts),
    .slot_keys        (slot_keys),
    .next_slot        (next_slot),
    .result           (match)
  );

  // output register frees up once its note-off beat is taken
  assign out_free = !out_valid || (notes.ready && phase);
  // unmapped events leave at once; mapped ones wait for the output register
  assign ev_adv   = ev_valid && (!match.hit || out_free);
  assign in_ready = !ev_valid || ev_adv;

  assign events.ready = in_ready;

  assign notes.valid        = out_valid;
  assign notes.out_channel  = out_channel;
  assign notes.out_key      = out_key;
  assign notes.out_velocity = phase ? '0 : out_velocity;
  assign notes.out_time     = out_time;
  assign notes.last         = phase;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      instrument_count <= '0;
      instrument_keys  <= '0;
      slot_counts      <= '0;
      slot_keys        <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_INST_COUNT:  instrument_count <= wr_data[CNT_W-1:0];
        REG_INST_KEYS:   instrument_keys  <= wr_data;
        REG_SLOT_COUNTS: slot_counts      <= wr_data[SCNTS_W-1:0];
        default: begin
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (wr_index == REG_SLOT0_KEYS + CFG_IDX_W'(s)) begin
              slot_keys[s] <= wr_data;
            end
          end
        end
      endcase
    end
  end

  // pointer update when a mapped event moves to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot <= '0;
    end else if (ev_adv && match.hit) begin
      for (int i = 0; i < NUM_INSTRUMENTS; i++) begin
        if (match.inst == INST_W'(i)) begin
          next_slot[i] <= match.ptr_next;
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (in_ready) begin
      ev_valid <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && events.valid) begin
      ev_is_note     <= events.is_note;
      ev_is_note_off <= events.is_note_off;
      ev_channel     <= events.channel;
      ev_key         <= events.key;
      ev_velocity    <= events.velocity;
      ev_time        <= events.event_time;
    end
  end

  // output register: two beats per mapped event; a new pair loads at the
  // edge that takes the previous note-off
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (ev_adv && match.hit) begin
      out_valid <= 1'b1;
      phase     <= 1'b0;
    end else if (out_valid && notes.ready) begin
      if (phase) begin
        out_valid <= 1'b0;
        phase     <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_adv && match.hit) begin
      out_channel  <= ev_channel;
      out_key      <= match.okey;
      out_velocity <= ev_velocity;
      out_time     <= ev_time;
    end
  end

endmodule

// File: sim/tb_drum_note_round_robin_mapper_top.sv
// ---------------------------------------------------------------------------
// tb_drum_note_round_robin_mapper_top: self-checking bench for the mapper
// A short table of directed events, then several random register setups with
// mostly instrument-key note-ons. Every note beat is checked against the table
// or an in-bench round-robin predictor. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_drum_note_round_robin_mapper_top;
  import drm_pkg::*;

  localparam int NUM_INST         = 8;
  localparam int NUM_SLOT         = 4;
  localparam int IDLE_PCT         = 28;      // idle / stall chance per cycle
  localparam int SETTLE_CYCLES    = 8;       // covers the input and output registers plus margin
  localparam int DRAIN_MAX        = 5000;    // bound on waiting for open beats
  localparam int CYCLE_LIMIT      = 200000;  // whole-run watchdog
  localparam int NUM_SETUPS       = 8;       // random register setups
  localparam int EVENTS_PER_SETUP = 53;      // events per setup, ~450 with the table
  localparam int STEADY_SETUP     = 5;       // setup run with no idling at all

  // index past the register list
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 3'd7;

  typedef struct packed {
    logic              is_note;
    logic              is_note_off;
    logic [CH_W-1:0]   channel;
    logic [KEY_W-1:0]  key;
    logic [VEL_W-1:0]  velocity;
    logic [TIME_W-1:0] stamp;
  } event_t;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [KEY_W-1:0]  key;
    logic [VEL_W-1:0]  vel;
    logic [TIME_W-1:0] stamp;
    logic              last;
  } note_t;

  // how a directed row gets its expected beats
  typedef enum {OUT_MODEL, OUT_NONE, OUT_PAIR} outcome_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [REG_W-1:0]     data;
    event_t               ev;
    outcome_t             outcome;
    logic [KEY_W-1:0]     out_key;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [REG_W-1:0]     wr_data;

  drm_event_if ev_bus ();
  drm_note_if  note_bus ();

  drum_note_round_robin_mapper_top #(
    .NUM_INSTRUMENTS(NUM_INST),
    .NUM_SLOTS      (NUM_SLOT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .events  (ev_bus),
    .notes   (note_bus)
  );

  // -------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and the slot pointers
  // -------------------------------------------------------------------------
  logic [CNT_W-1:0]   cfg_count;
  logic [REG_W-1:0]   cfg_keys;
  logic [SCNTS_W-1:0] cfg_slot_counts;
  logic [REG_W-1:0]   cfg_slot_keys [NUM_SLOT];
  logic [PTR_W-1:0]   rr_next [NUM_INST];

  note_t pending_beats [$];   // note beats still owed by the block
  row_t  plan [$];            // directed stimulus table

  int  errors        = 0;
  int  events_sent   = 0;
  int  beats_checked = 0;
  int  reg_writes    = 0;
  bit  steady        = 1'b0;  // suppresses idling on both sides

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("drum_note_round_robin_mapper_top verification failed");
    $finish;
  end

  function automatic string beat_str(input note_t b);
    return $sformatf("ch=%0d key=%0d vel=%0d time=%h last=%0b",
                     b.ch, b.key, b.vel, b.stamp, b.last);
  endfunction

  // Round-robin lookup. Updates the pointer of the chosen instrument and
  // returns the note-on beat when the event maps to an output key.
  function automatic bit map_event(input event_t e, output note_t on_beat);
    int n;
    int cnt;
    int slot;
    on_beat = '0;
    if (!e.is_note || e.is_note_off) return 1'b0;
    // counts past the instrument table act as a full table
    n = (cfg_count > NUM_INST) ? NUM_INST : int'(cfg_count);
    for (int i = 0; i < n; i++) begin
      if (cfg_keys[KEY_W*i +: KEY_W] == e.key) begin
        // only the first match counts, even when its slot list is empty
        cnt = int'(cfg_slot_counts[SCNT_W*i +: SCNT_W]);
        if (cnt > NUM_SLOT) cnt = NUM_SLOT;
        if (cnt == 0) return 1'b0;
        // a stale pointer (count lowered since) falls back to slot 0
        slot = int'(rr_next[i]);
        if (slot >= cnt) slot = 0;
        rr_next[i] = PTR_W'(slot + 1);
        on_beat = '{ch: e.channel, key: cfg_slot_keys[slot][KEY_W*i +: KEY_W],
                    vel: e.velocity, stamp: e.stamp, last: 1'b0};
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // a mapped event owes a note-on then a note-off with velocity 0
  task automatic push_pair(input note_t on_beat);
    pending_beats.push_back(on_beat);
    on_beat.vel  = '0;
    on_beat.last = 1'b1;
    pending_beats.push_back(on_beat);
  endtask

  function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [REG_W-1:0] data);
    row_t r;
    r = '{is_cfg: 1'b1, idx: idx, data: data, ev: '0, outcome: OUT_NONE,
          out_key: '0};
    plan.push_back(r);
  endfunction

  function automatic void plan_note(input int is_note, input int is_off,
                                    input int ch, input int key, input int vel,
                                    input logic [TIME_W-1:0] stamp,
                                    input outcome_t outcome, input int out_key);
    row_t r;
    r = '{is_cfg: 1'b0, idx: '0, data: '0, ev: '0, outcome: outcome,
          out_key: KEY_W'(out_key)};
    r.ev = '{is_note: 1'(is_note), is_note_off: 1'(is_off), channel: CH_W'(ch),
             key: KEY_W'(key), velocity: VEL_W'(vel), stamp: stamp};
    plan.push_back(r);
  endfunction

  // Register write on the config port; the model follows at once since the
  // block is idle whenever this runs. wr_en is lowered by whoever comes next.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    case (idx)
      REG_INST_COUNT:  cfg_count        = data[CNT_W-1:0];
      REG_INST_KEYS:   cfg_keys         = data;
      REG_SLOT_COUNTS: cfg_slot_counts  = data[SCNTS_W-1:0];
      REG_SLOT0_KEYS:  cfg_slot_keys[0] = data;
      REG_SLOT1_KEYS:  cfg_slot_keys[1] = data;
      REG_SLOT2_KEYS:  cfg_slot_keys[2] = data;
      REG_SLOT3_KEYS:  cfg_slot_keys[3] = data;
      default: ;  // unknown index: ignored by the block
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // One event beat: random idle gap, then hold valid until ready is seen.
  // Returns at the edge that accepted the beat with valid still high, so a
  // following call keeps it high without a low/high glitch.
  task automatic send_event(input event_t e);
    wr_en <= 1'b0;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      ev_bus.valid <= 1'b0;
      @(posedge clk);
    end
    ev_bus.valid       <= 1'b1;
    ev_bus.is_note     <= e.is_note;
    ev_bus.is_note_off <= e.is_note_off;
    ev_bus.channel     <= e.channel;
    ev_bus.key         <= e.key;
    ev_bus.velocity    <= e.velocity;
    ev_bus.event_time  <= e.stamp;
    @(posedge clk);
    while (!ev_bus.ready) @(posedge clk);
    events_sent++;
  endtask

  // Drop valid, wait for every owed beat, then let any event that maps to
  // nothing clear the pipe. Beats still owed after that are failures.
  task automatic settle();
    int waited;
    waited = 0;
    ev_bus.valid <= 1'b0;
    while (pending_beats.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_beats.size() != 0) begin
      errors++;
      $display("%0t: %0d note beats missing, expected %s, actual none",
               $time, pending_beats.size(), beat_str(pending_beats[0]));
      pending_beats.delete();
    end
  endtask

  // Random register setup. Setup 0 is all ones everywhere (count and slot
  // counts past their limits, every key 127), setup 1 all-zero keys.
  task automatic new_setup(input int p);
    logic [REG_W-1:0]   keys;
    logic [SCNTS_W-1:0] cnts;
    int                 j;
    if (p == 0) begin
      write_reg(REG_INST_COUNT, '1);
      write_reg(REG_INST_KEYS, '1);
      write_reg(REG_SLOT_COUNTS, '1);
      write_reg(REG_SLOT0_KEYS, '1);
      write_reg(REG_SLOT1_KEYS, '1);
      write_reg(REG_SLOT2_KEYS, '1);
      write_reg(REG_SLOT3_KEYS, '1);
    end else begin
      keys = '0;
      // random keys, a quarter of them copies of an earlier instrument's
      for (int i = 0; i < NUM_INST && p != 1; i++) begin
        if (i > 0 && $urandom_range(0, 3) == 0) begin
          j = $urandom_range(0, i - 1);
          keys[KEY_W*i +: KEY_W] = keys[KEY_W*j +: KEY_W];
        end else begin
          keys[KEY_W*i +: KEY_W] = KEY_W'($urandom);
        end
      end
      cnts = SCNTS_W'($urandom);
      write_reg(REG_SLOT_COUNTS, REG_W'(cnts));
      write_reg(REG_INST_KEYS, keys);
      write_reg(REG_INST_COUNT, (p == 1) ? REG_W'(NUM_INST) : REG_W'($urandom_range(1, 15)));
      for (int s = 0; s < NUM_SLOT; s++)
        write_reg(REG_SLOT0_KEYS + CFG_IDX_W'(s),
                  (p == 1) ? '0 : REG_W'({$urandom, $urandom}));
      if (p == 2) write_reg(REG_UNUSED, REG_W'({$urandom, $urandom}));
    end
  endtask

  // Mostly note-ons on a configured key (maybe past the active count),
  // the rest stray note-ons, note-offs and non-note events.
  function automatic event_t random_event();
    event_t e;
    int     r;
    int     inst;
    r    = $urandom_range(0, 99);
    inst = $urandom_range(0, NUM_INST - 1);
    e.is_note     = 1'b1;
    e.is_note_off = 1'b0;
    e.channel     = CH_W'($urandom);
    e.key         = KEY_W'($urandom);
    e.velocity    = VEL_W'($urandom);
    e.stamp       = $urandom;
    if (r < 72) begin
      e.key = cfg_keys[KEY_W*inst +: KEY_W];
    end else if (r >= 91) begin
      e.is_note     = 1'b0;
      e.is_note_off = 1'($urandom);
    end else if (r >= 82) begin
      e.is_note_off = 1'b1;
      if (r >= 87) e.key = cfg_keys[KEY_W*inst +: KEY_W];
    end
    return e;
  endfunction

  // -------------------------------------------------------------------------
  // Note sink: random stalls, each accepted beat checked in order
  // -------------------------------------------------------------------------
  initial begin : note_sink
    note_t seen;
    note_t want;
    note_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        note_bus.ready <= 1'b0;
      end else begin
        if (note_bus.valid && note_bus.ready) begin
          seen = '{ch: note_bus.out_channel, key: note_bus.out_key,
                   vel: note_bus.out_velocity, stamp: note_bus.out_time,
                   last: note_bus.last};
          if (pending_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected note beat, expected none, actual %s",
                     $time, beat_str(seen));
          end else begin
            want = pending_beats.pop_front();
            beats_checked++;
            if (seen !== want) begin
              errors++;
              $display("%0t: note beat mismatch, expected %s, actual %s",
                       $time, beat_str(want), beat_str(seen));
            end
          end
        end
        note_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    event_t e;
    note_t  on_beat;
    note_t  want_beat;
    bit     hit;

    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = '0;
    wr_data            = '0;
    ev_bus.valid       = 1'b0;
    ev_bus.is_note     = 1'b0;
    ev_bus.is_note_off = 1'b0;
    ev_bus.channel     = '0;
    ev_bus.key         = '0;
    ev_bus.velocity    = '0;
    ev_bus.event_time  = '0;
    cfg_count          = '0;
    cfg_keys           = '0;
    cfg_slot_counts    = '0;
    foreach (cfg_slot_keys[s]) cfg_slot_keys[s] = '0;
    foreach (rr_next[i]) rr_next[i] = '0;

    // Directed table. Layout of the main setup, instrument 0 first:
    //   input keys   36 38 127 0 36 42 42 50
    //   slot counts   3  1   4 2  2  0  2  7   (7 acts as 4)
    //   slot s key of instrument i is 10*(s+1)+i, slot 3 keys all 127
    // Count 15 acts as 8. Instrument 4 repeats key 36 and is never reached;
    // instrument 5 is empty and shadows instrument 6.
    plan_note(1, 0, 15, 0, 127, 32'hFFFF_FFFF, OUT_NONE, 0);  // after reset
    plan_write(REG_UNUSED, '1);
    plan_write(REG_INST_COUNT, REG_W'(15));
    plan_write(REG_INST_KEYS,
               {7'd50, 7'd42, 7'd42, 7'd36, 7'd0, 7'd127, 7'd38, 7'd36});
    plan_write(REG_SLOT_COUNTS,
               REG_W'({3'd7, 3'd2, 3'd0, 3'd2, 3'd2, 3'd4, 3'd1, 3'd3}));
    plan_write(REG_SLOT0_KEYS,
               {7'd17, 7'd16, 7'd15, 7'd14, 7'd13, 7'd12, 7'd11, 7'd10});
    plan_write(REG_SLOT1_KEYS,
               {7'd27, 7'd26, 7'd25, 7'd24, 7'd23, 7'd22, 7'd21, 7'd20});
    plan_write(REG_SLOT2_KEYS,
               {7'd37, 7'd36, 7'd35, 7'd34, 7'd33, 7'd32, 7'd31, 7'd30});
    plan_write(REG_SLOT3_KEYS, {8{7'd127}});
    plan_note(1, 0, 15, 36, 127, 32'hFFFF_FFFF, OUT_PAIR, 10);
    plan_note(1, 0,  0, 36,   0, 32'h0000_0000, OUT_PAIR, 20);
    plan_note(1, 0,  5, 36,  64, 32'h8000_0000, OUT_PAIR, 30);
    plan_note(1, 0,  9, 36,   1, 32'h0000_0001, OUT_PAIR, 10);   // wraps
    plan_note(1, 1,  3, 36, 100, 32'h1234_5678, OUT_NONE, 0);    // note-off
    plan_note(0, 1,  3, 36, 100, 32'h1234_5679, OUT_NONE, 0);    // not a note
    plan_note(1, 0,  1, 38,  77, 32'h0000_0100, OUT_PAIR, 11);   // one slot
    plan_note(1, 0,  2, 38,  78, 32'h0000_0101, OUT_PAIR, 11);
    plan_note(1, 0,  4, 127, 127, 32'hAAAA_AAAA, OUT_PAIR, 12);
    plan_note(1, 0,  4, 127, 126, 32'h5555_5555, OUT_PAIR, 22);
    plan_note(1, 0,  4, 127, 125, 32'hDEAD_BEEF, OUT_PAIR, 32);
    plan_note(1, 0,  4, 127, 124, 32'hCAFE_0000, OUT_PAIR, 127);
    plan_note(1, 0,  4, 127, 123, 32'h0000_CAFE, OUT_PAIR, 12);
    plan_note(1, 0,  7,  0,  50, 32'h0F0F_0F0F, OUT_PAIR, 13);   // key 0
    plan_note(1, 0,  8, 42,  90, 32'hF0F0_F0F0, OUT_NONE, 0);    // empty first
    plan_note(1, 0, 10, 50,  10, 32'h0000_0200, OUT_PAIR, 17);   // count 7 -> 4
    plan_note(1, 0, 11, 50,  11, 32'h0000_0201, OUT_PAIR, 27);
    plan_note(1, 0, 12, 50,  12, 32'h0000_0202, OUT_PAIR, 37);
    plan_note(1, 0, 13, 50,  13, 32'h0000_0203, OUT_PAIR, 127);
    plan_note(1, 0, 14, 50,  14, 32'h0000_0204, OUT_PAIR, 17);
    plan_note(1, 0,  6, 99,  99, 32'h7FFF_FFFF, OUT_NONE, 0);    // no match
    // lower instrument 2 to one slot while its pointer sits at slot 1
    plan_write(REG_SLOT_COUNTS,
               REG_W'({3'd7, 3'd2, 3'd0, 3'd2, 3'd2, 3'd1, 3'd1, 3'd3}));
    plan_note(1, 0,  2, 127, 60, 32'h0101_0101, OUT_MODEL, 0);
    // instrument 7 drops out of the search
    plan_write(REG_INST_COUNT, REG_W'(7));
    plan_note(1, 0,  3, 50,  61, 32'h0202_0202, OUT_NONE, 0);
    plan_note(1, 0,  5, 36,  62, 32'h0303_0303, OUT_MODEL, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // walk the table; registers change only with the pipe empty
    for (int r = 0; r < plan.size(); r++) begin
      if (plan[r].is_cfg) begin
        if (r > 0 && !plan[r-1].is_cfg) settle();
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        send_event(plan[r].ev);
        hit = map_event(plan[r].ev, on_beat);
        case (plan[r].outcome)
          OUT_MODEL: if (hit) push_pair(on_beat);
          OUT_PAIR: begin
            want_beat = '{ch: plan[r].ev.channel, key: plan[r].out_key,
                          vel: plan[r].ev.velocity, stamp: plan[r].ev.stamp,
                          last: 1'b0};
            push_pair(want_beat);
          end
          default: ;
        endcase
      end
    end

    // random part: pointers carry across setups, so counts lowered under a
    // live pointer get exercised as well
    for (int p = 0; p < NUM_SETUPS; p++) begin
      settle();
      steady = (p == STEADY_SETUP);
      new_setup(p);
      for (int k = 0; k < EVENTS_PER_SETUP; k++) begin
        e = random_event();
        send_event(e);
        if (map_event(e, on_beat)) push_pair(on_beat);
      end
    end
    steady = 1'b0;
    settle();

    $display("%0d event beats sent, %0d note beats checked, %0d register writes",
             events_sent, beats_checked, reg_writes);
    $display("directed table of %0d rows, then %0d random setups incl. all-ones",
             plan.size(), NUM_SETUPS);
    if (errors == 0) begin
      $display("drum_note_round_robin_mapper_top verification clean");
    end else begin
      $display("drum_note_round_robin_mapper_top verification failed");
    end
    $finish;
  end

endmodule
